>>> src/wfc_pkg.sv
// Shared types and constants for the word frequency counter.
`timescale 1ns / 1ps
`default_nettype none
package wfc_pkg;

  localparam int unsigned DICT_ENTRIES_DEF = 256;
  localparam int unsigned MAX_WORD_LEN_DEF = 16;
  localparam int unsigned LETTER_W         = 5;
  localparam int unsigned INDEX_W          = 9;
  localparam int unsigned COUNT_W          = 32;

  localparam logic [7:0] CHAR_LO_A = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_LO_Z = 8'h7A;  // 'z'
  localparam logic [7:0] CHAR_UP_A = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_UP_Z = 8'h5A;  // 'Z'

  localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

  typedef struct packed {
    logic [7:0] char_code;
    logic       line_end;
  } in_data_t;

  typedef struct packed {
    logic [INDEX_W-1:0] word_index;
    logic [COUNT_W-1:0] word_count;
    logic               is_new;
    logic               dict_full;
    logic               truncated;
    logic [COUNT_W-1:0] total_words;
  } out_data_t;

  // control broadcast to every dictionary cell
  typedef struct packed {
    logic cmp_en;     // register the compare result
    logic upd_en;     // apply the count update or insert
    logic insert_en;  // word missed and there is room
  } cell_ctrl_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == COUNT_SAT) ? v : v + COUNT_W'(1);
  endfunction

endpackage
`default_nettype wire

>>> src/wfc_cell.sv
// One dictionary entry: stored word, length, count and compare logic.
`timescale 1ns / 1ps
`default_nettype none
module wfc_cell #(
  parameter int unsigned MAX_WORD_LEN = wfc_pkg::MAX_WORD_LEN_DEF,
  localparam int unsigned LEN_W = $clog2(MAX_WORD_LEN + 1),
  localparam int unsigned WORD_W = MAX_WORD_LEN * wfc_pkg::LETTER_W
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire wfc_pkg::cell_ctrl_t         ctrl_i,
  input  wire logic [WORD_W-1:0]           cmp_letters_i,
  input  wire logic [LEN_W-1:0]            cmp_len_i,
  input  wire logic                        prev_valid_i,
  output logic                             valid_o,
  output logic                             match_o,
  output logic [wfc_pkg::COUNT_W-1:0]      count_o
);
  import wfc_pkg::*;

  logic                valid_r;
  logic                match_r;
  logic [WORD_W-1:0]   letters_r;
  logic [LEN_W-1:0]    len_r;
  logic [COUNT_W-1:0]  count_r;
  logic                hit;
  logic                take;

  // compare stored word with the broadcast word, letters past the length ignored
  always_comb begin
    hit = valid_r && (len_r == cmp_len_i);
    for (int k = 0; k < MAX_WORD_LEN; k++) begin
      if (LEN_W'(k) < cmp_len_i &&
          letters_r[k*LETTER_W +: LETTER_W] != cmp_letters_i[k*LETTER_W +: LETTER_W]) begin
        hit = 1'b0;
      end
    end
  end

  // first free cell in the chain takes an inserted word
  assign take = ctrl_i.upd_en && ctrl_i.insert_en && prev_valid_i && !valid_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      if (ctrl_i.cmp_en) begin
        match_r <= hit;
      end
      if (take) begin
        valid_r <= 1'b1;
      end
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (take) begin
      letters_r <= cmp_letters_i;
      len_r     <= cmp_len_i;
      count_r   <= COUNT_W'(1);
    end else if (ctrl_i.upd_en && match_r) begin
      count_r   <= sat_inc(count_r);
    end
  end

  assign valid_o = valid_r;
  assign match_o = match_r;
  assign count_o = count_r;

endmodule
`default_nettype wire

>>> src/word_frequency_counter_unit.sv
// Top level: word assembly, dictionary cell chain and result register.
// Sequence: a word-ending byte's transfer starts the compare step; the update
//   step then registers the result and raises out_strobe.
// Throughput: letters 1 per cycle while not busy; a word end holds busy through
//   the parallel compare in the cell row and the update, until its result is out.
// Reset: synchronous active low; clears word state, cell valid bits and counters.
// Results are held one cycle under out_strobe; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module word_frequency_counter_unit #(
  parameter int unsigned DICT_ENTRIES = wfc_pkg::DICT_ENTRIES_DEF,
  parameter int unsigned MAX_WORD_LEN = wfc_pkg::MAX_WORD_LEN_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire wfc_pkg::in_data_t  in_data,
  output logic                    out_strobe,
  output wfc_pkg::out_data_t      out_data
);
  import wfc_pkg::*;

  localparam int unsigned LEN_W  = $clog2(MAX_WORD_LEN + 1);
  localparam int unsigned WORD_W = MAX_WORD_LEN * LETTER_W;
  localparam int unsigned USED_W = $clog2(DICT_ENTRIES + 1);
  localparam logic [LEN_W-1:0]  MAX_LEN = LEN_W'(MAX_WORD_LEN);
  localparam logic [USED_W-1:0] FULL_AT = USED_W'(DICT_ENTRIES);

  typedef enum logic [1:0] {ST_IDLE, ST_CMP, ST_UPD} state_t;

  state_t              state_r;
  logic                in_word_r;
  logic [LEN_W-1:0]    cur_len_r;
  logic                cur_trunc_r;
  logic [WORD_W-1:0]   cur_letters_r;
  logic [WORD_W-1:0]   cmp_letters_r;
  logic [LEN_W-1:0]    cmp_len_r;
  logic                cmp_trunc_r;
  logic [USED_W-1:0]   used_r;
  logic [COUNT_W-1:0]  seen_r;
  logic                out_strobe_r;
  out_data_t           out_data_r;

  logic                acc;
  logic                is_letter;
  logic [LETTER_W-1:0] code;
  logic                finish;
  logic [WORD_W-1:0]   letters_nxt;
  logic [LEN_W-1:0]    len_nxt;
  logic                trunc_nxt;

  cell_ctrl_t          ctrl;
  logic [DICT_ENTRIES-1:0] valid_vec;
  logic [DICT_ENTRIES-1:0] match_vec;
  logic [COUNT_W-1:0]  cell_count [DICT_ENTRIES];
  logic                any_hit;
  logic                full;
  logic [INDEX_W-1:0]  hit_index;
  logic [COUNT_W-1:0]  hit_count;
  logic [COUNT_W-1:0]  seen_nxt;

  assign acc  = start && !busy;
  assign busy = (state_r != ST_IDLE);

  // classify the byte
  always_comb begin
    is_letter = 1'b0;
    code      = '0;
    if (in_data.char_code >= CHAR_LO_A && in_data.char_code <= CHAR_LO_Z) begin
      is_letter = 1'b1;
      code      = LETTER_W'(in_data.char_code - CHAR_LO_A);
    end else if (in_data.char_code >= CHAR_UP_A && in_data.char_code <= CHAR_UP_Z) begin
      is_letter = 1'b1;
      code      = LETTER_W'(in_data.char_code - CHAR_UP_A);
    end
  end

  // word being assembled, including this byte
  always_comb begin
    letters_nxt = cur_letters_r;
    len_nxt     = cur_len_r;
    trunc_nxt   = cur_trunc_r;
    if (is_letter) begin
      if (cur_len_r < MAX_LEN) begin
        for (int k = 0; k < MAX_WORD_LEN; k++) begin
          if (LEN_W'(k) == cur_len_r) begin
            letters_nxt[k*LETTER_W +: LETTER_W] = code;
          end
        end
        len_nxt = cur_len_r + LEN_W'(1);
      end else begin
        trunc_nxt = 1'b1;
      end
    end
  end

  assign finish = is_letter ? in_data.line_end : in_word_r;

  // cell control
  assign full           = (used_r == FULL_AT);
  assign any_hit        = |match_vec;
  assign ctrl.cmp_en    = (state_r == ST_CMP);
  assign ctrl.upd_en    = (state_r == ST_UPD);
  assign ctrl.insert_en = !any_hit && !full;

  // row of dictionary cells, valid handed along the chain
  for (genvar i = 0; i < DICT_ENTRIES; i++) begin : g_cell
    wfc_cell #(.MAX_WORD_LEN(MAX_WORD_LEN)) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctrl_i       (ctrl),
      .cmp_letters_i(cmp_letters_r),
      .cmp_len_i    (cmp_len_r),
      .prev_valid_i ((i == 0) ? 1'b1 : valid_vec[(i == 0) ? 0 : i-1]),
      .valid_o      (valid_vec[i]),
      .match_o      (match_vec[i]),
      .count_o      (cell_count[i])
    );
  end

  // encode the matching cell and pick its count
  always_comb begin
    hit_index = '0;
    hit_count = '0;
    for (int i = 0; i < DICT_ENTRIES; i++) begin
      if (match_vec[i]) begin
        hit_index = hit_index | INDEX_W'(i);
        hit_count = hit_count | cell_count[i];
      end
    end
  end

  assign seen_nxt = sat_inc(seen_r);

  // sequencer, word state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      in_word_r    <= 1'b0;
      cur_len_r    <= '0;
      cur_trunc_r  <= 1'b0;
      used_r       <= '0;
      seen_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (acc) begin
            if (finish) begin
              in_word_r   <= 1'b0;
              cur_len_r   <= '0;
              cur_trunc_r <= 1'b0;
              state_r     <= ST_CMP;
            end else if (is_letter) begin
              in_word_r   <= 1'b1;
              cur_len_r   <= len_nxt;
              cur_trunc_r <= trunc_nxt;
            end
          end
        end
        ST_CMP: begin
          state_r <= ST_UPD;
        end
        ST_UPD: begin
          state_r      <= ST_IDLE;
          out_strobe_r <= 1'b1;
          seen_r       <= seen_nxt;
          if (!any_hit && !full) begin
            used_r <= used_r + USED_W'(1);
          end
          out_data_r.truncated   <= cmp_trunc_r;
          out_data_r.total_words <= seen_nxt;
          out_data_r.is_new      <= !any_hit && !full;
          out_data_r.dict_full   <= !any_hit && full;
          if (any_hit) begin
            out_data_r.word_index <= hit_index;
            out_data_r.word_count <= sat_inc(hit_count);
          end else if (full) begin
            out_data_r.word_index <= INDEX_W'(DICT_ENTRIES);
            out_data_r.word_count <= '0;
          end else begin
            out_data_r.word_index <= INDEX_W'(used_r);
            out_data_r.word_count <= COUNT_W'(1);
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      cur_letters_r <= letters_nxt;
    end
    if (acc && finish) begin
      cmp_letters_r <= letters_nxt;
      cmp_len_r     <= len_nxt;
      cmp_trunc_r   <= trunc_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // a word lives in at most one cell
  a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_vec))
    else $error("several dictionary cells matched one word");

  // fill count never passes the cell row
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= FULL_AT)
    else $error("dictionary fill count out of range");

  // a result follows only the update step
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(state_r == ST_UPD))
    else $error("result strobe without update step");

  // number of valid cells matches the fill count
  a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(used_r))
    else $error("cell valid bits disagree with fill count");

endmodule
`default_nettype wire

>>> tb/sv/tb_word_frequency_counter_unit.sv
// Testbench for the word frequency counter: byte stream stimulus, word-count prediction, result checks.
`timescale 1ns / 1ps
`default_nettype none
module tb_word_frequency_counter_unit;
  import wfc_pkg::*;

  localparam int unsigned N_ENTRIES = DICT_ENTRIES_DEF;
  localparam int unsigned WORD_MAX  = MAX_WORD_LEN_DEF;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_data_t  in_data;
  logic      out_strobe;
  out_data_t out_data;

  word_frequency_counter_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  // Clock: 10 ns period
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Predictor state
  logic                 pend_active;
  int unsigned          pend_len;
  logic                 pend_cut;
  logic [4:0]           pend_letters [WORD_MAX];
  logic [4:0]           vocab_letters[N_ENTRIES][WORD_MAX];
  int unsigned          vocab_len    [N_ENTRIES];
  logic [COUNT_W-1:0]   vocab_count  [N_ENTRIES];
  int unsigned          vocab_used;
  logic [COUNT_W-1:0]   word_total;

  out_data_t            expected_words[$];
  int                   error_count;

  // Look up the pending word, update the vocabulary and queue its result
  task automatic close_word();
    out_data_t r;
    int unsigned e;
    int unsigned k;
    logic hit;
    e = 0;
    hit = 1'b0;
    while (e < vocab_used && !hit) begin
      hit = (vocab_len[e] == pend_len);
      for (k = 0; k < pend_len; k++)
        if (vocab_letters[e][k] != pend_letters[k]) hit = 1'b0;
      if (!hit) e++;
    end
    r = '0;
    r.word_index = INDEX_W'(N_ENTRIES);
    if (hit) begin
      if (vocab_count[e] != COUNT_SAT) vocab_count[e]++;
      r.word_index = INDEX_W'(e);
      r.word_count = vocab_count[e];
    end else if (vocab_used < N_ENTRIES) begin
      for (k = 0; k < pend_len; k++) vocab_letters[vocab_used][k] = pend_letters[k];
      vocab_len[vocab_used]   = pend_len;
      vocab_count[vocab_used] = 1;
      r.word_index = INDEX_W'(vocab_used);
      r.word_count = 1;
      r.is_new     = 1'b1;
      vocab_used++;
    end else begin
      r.dict_full = 1'b1;
    end
    if (word_total != COUNT_SAT) word_total++;
    r.truncated   = pend_cut;
    r.total_words = word_total;
    expected_words.insert(expected_words.size(), r);
    pend_active = 1'b0;
    pend_len    = 0;
    pend_cut    = 1'b0;
  endtask

  // Work out what one accepted byte causes
  task automatic predict_byte(input in_data_t d);
    logic       alpha;
    logic [4:0] code;
    alpha = 1'b0;
    code  = '0;
    if (d.char_code >= CHAR_LO_A && d.char_code <= CHAR_LO_Z) begin
      alpha = 1'b1;
      code  = 5'(d.char_code - CHAR_LO_A);
    end else if (d.char_code >= CHAR_UP_A && d.char_code <= CHAR_UP_Z) begin
      alpha = 1'b1;
      code  = 5'(d.char_code - CHAR_UP_A);
    end
    if (alpha) begin
      if (pend_len < WORD_MAX) begin
        pend_letters[pend_len] = code;
        pend_len++;
      end else begin
        pend_cut = 1'b1;
      end
      pend_active = 1'b1;
      if (d.line_end) close_word();
    end else if (pend_active) begin
      close_word();
    end
  endtask

  // Sender pacing: bursts with random gaps
  int burst_left;

  // Send one byte and wait for its transfer
  task automatic send_byte(input logic [7:0] c, input logic eol);
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 3) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    start           <= 1'b1;
    in_data.char_code <= c;
    in_data.line_end  <= eol;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_byte('{char_code: c, line_end: eol});
  endtask

  task automatic send_text(input string s, input logic eol_last);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i], eol_last && (i == s.len() - 1));
  endtask

  // Result checker
  always @(posedge clk) begin
    out_data_t want;
    if (rst_n && out_strobe) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        error_count++;
      end else begin
        want = expected_words.pop_front();
        if (out_data.word_index != want.word_index) begin
          $display("%0t: word_index exp %0d got %0d", $time, want.word_index,
                   out_data.word_index);
          error_count++;
        end
        if (out_data.word_count != want.word_count) begin
          $display("%0t: word_count exp %0d got %0d", $time, want.word_count,
                   out_data.word_count);
          error_count++;
        end
        if (out_data.is_new != want.is_new) begin
          $display("%0t: is_new exp %0b got %0b", $time, want.is_new, out_data.is_new);
          error_count++;
        end
        if (out_data.dict_full != want.dict_full) begin
          $display("%0t: dict_full exp %0b got %0b", $time, want.dict_full,
                   out_data.dict_full);
          error_count++;
        end
        if (out_data.truncated != want.truncated) begin
          $display("%0t: truncated exp %0b got %0b", $time, want.truncated,
                   out_data.truncated);
          error_count++;
        end
        if (out_data.total_words != want.total_words) begin
          $display("%0t: total_words exp %0d got %0d", $time, want.total_words,
                   out_data.total_words);
          error_count++;
        end
      end
    end
  end

  // Stop sending and wait until every queued result has come
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // Letter of a random case from the first span letters, so small spans repeat words
  function automatic logic [7:0] rand_letter(input int span);
    logic [7:0] base;
    base = $urandom_range(0, 1) ? CHAR_LO_A : CHAR_UP_A;
    return base + 8'($urandom_range(0, span - 1));
  endfunction

  // Separator: any non-letter byte
  function automatic logic [7:0] rand_separator();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while ((c >= CHAR_LO_A && c <= CHAR_LO_Z) || (c >= CHAR_UP_A && c <= CHAR_UP_Z))
      c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // Directed: case folding, extremes of the byte, line ends, overlong word
  task automatic test_directed();
    send_text("aZ", 1'b0);
    send_byte(8'h00, 1'b0);
    send_text("Az", 1'b1);
    send_text("zz", 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h20, 1'b1);
    send_text("abcdefghijklmnopqrstu", 1'b0);
    send_byte(CHAR_LO_A - 8'd1, 1'b0);
    send_text("ABCDEFGHIJKLMNOP", 1'b1);
    send_byte(CHAR_UP_Z + 8'd1, 1'b0);
    drain_results();
  endtask

  // Random text: mostly words over the first span letters, some noise
  task automatic test_random_text(input int n_bytes, input int span);
    int i;
    int len;
    i = 0;
    while (i < n_bytes) begin
      if ($urandom_range(0, 9) == 0) begin
        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        i++;
      end else begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 4);
        repeat (len) begin
          send_byte(rand_letter(span), ($urandom_range(0, 19) == 0));
          i++;
        end
        send_byte(rand_separator(), 1'($urandom_range(0, 1)));
        i++;
      end
    end
  endtask

  // Pause until every result is in, then carry on
  task automatic test_pause();
    drain_results();
    repeat (5) @(posedge clk);
  endtask

  // Fill the dictionary with distinct two-letter words ended by line end, then overflow it
  task automatic test_dict_fill();
    int w;
    for (w = 0; w < N_ENTRIES + 20; w++) begin
      send_byte(CHAR_LO_A + 8'(w % 26), 1'b0);
      send_byte(CHAR_UP_A + 8'((w / 26) % 26), 1'b1);
    end
  endtask

  // Stop after a generous time
  initial begin
    #20ms;
    $display("[word_frequency_counter_unit] ERROR");
    $finish;
  end

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_data     = '0;
    pend_active = 1'b0;
    pend_len    = 0;
    pend_cut    = 1'b0;
    vocab_used  = 0;
    word_total  = '0;
    error_count = 0;
    burst_left  = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_text(250, 4);
    test_pause();
    test_dict_fill();
    test_random_text(300, 26);
    drain_results();
    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("[word_frequency_counter_unit] OK");
    else
      $display("[word_frequency_counter_unit] ERROR");
    $finish;
  end
endmodule
`default_nettype wire
